[sv/power_button_rail_sequencer_top_defines.svh]
// ----------------------------------------------------------------------------
// power button rail sequencer assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef POWER_BUTTON_RAIL_SEQUENCER_TOP_DEFINES_SVH
`define POWER_BUTTON_RAIL_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define PBRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pbrs_pkg.sv]
// ----------------------------------------------------------------------------
// pbrs_pkg
// shared types, register map and phase codes of the rail sequencer
// ----------------------------------------------------------------------------
package pbrs_pkg;

	localparam int DLY_W  = 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [DLY_W-1:0] HOLD_MAX = {DLY_W{1'b1}};

	// register indexes
	localparam logic [2:0] REG_LONG_PRESS  = 3'd0;
	localparam logic [2:0] REG_R3_TO_R24   = 3'd1;
	localparam logic [2:0] REG_R24_TO_RST  = 3'd2;
	localparam logic [2:0] REG_RST_TO_R24  = 3'd3;
	localparam logic [2:0] REG_R24_TO_R3   = 3'd4;

	// register reset values
	localparam logic [DLY_W-1:0] RST_LONG_PRESS = 16'd3000;
	localparam logic [DLY_W-1:0] RST_R3_TO_R24  = 16'd100;
	localparam logic [DLY_W-1:0] RST_R24_TO_RST = 16'd500;
	localparam logic [DLY_W-1:0] RST_RST_TO_R24 = 16'd100;
	localparam logic [DLY_W-1:0] RST_R24_TO_R3  = 16'd50;

	// sequencer phases
	localparam logic [2:0] PH_OFF         = 3'd0;
	localparam logic [2:0] PH_UP_WAIT24   = 3'd1;
	localparam logic [2:0] PH_UP_WAIT_RST = 3'd2;
	localparam logic [2:0] PH_ON          = 3'd3;
	localparam logic [2:0] PH_DOWN_WAIT24 = 3'd4;
	localparam logic [2:0] PH_DOWN_WAIT3  = 3'd5;

	typedef struct packed {
		logic button_level;
		logic clear_flag;
	} tick_t;

	typedef struct packed {
		logic rail3_enable;
		logic rail24_enable;
		logic reset_release;
		logic system_on;
		logic button_flag;
		logic start_pulse;
		logic stop_pulse;
	} result_t;

	typedef struct packed {
		logic [DLY_W-1:0] long_press_ms;
		logic [DLY_W-1:0] rail3_to_rail24_on_ms;
		logic [DLY_W-1:0] rail24_to_reset_release_ms;
		logic [DLY_W-1:0] reset_to_rail24_off_ms;
		logic [DLY_W-1:0] rail24_to_rail3_off_ms;
	} cfg_t;

endpackage

[sv/pbrs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pbrs_cfg_regs
// apb register bank holding the press limit and the rail delays
// ----------------------------------------------------------------------------
module pbrs_cfg_regs
	import pbrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms              <= RST_LONG_PRESS;
			cfg_q.rail3_to_rail24_on_ms      <= RST_R3_TO_R24;
			cfg_q.rail24_to_reset_release_ms <= RST_R24_TO_RST;
			cfg_q.reset_to_rail24_off_ms     <= RST_RST_TO_R24;
			cfg_q.rail24_to_rail3_off_ms     <= RST_R24_TO_R3;
		end else if (wr_en) begin
			unique case (idx)
				REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[DLY_W-1:0];
				REG_R3_TO_R24:  cfg_q.rail3_to_rail24_on_ms <= pwdata[DLY_W-1:0];
				REG_R24_TO_RST: cfg_q.rail24_to_reset_release_ms <= pwdata[DLY_W-1:0];
				REG_RST_TO_R24: cfg_q.reset_to_rail24_off_ms <= pwdata[DLY_W-1:0];
				REG_R24_TO_R3:  cfg_q.rail24_to_rail3_off_ms <= pwdata[DLY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LONG_PRESS: prdata = {{(DATA_W-DLY_W){1'b0}}, cfg_q.long_press_ms};
			REG_R3_TO_R24:  prdata = {{(DATA_W-DLY_W){1'b0}}, cfg_q.rail3_to_rail24_on_ms};
			REG_R24_TO_RST: prdata = {{(DATA_W-DLY_W){1'b0}}, cfg_q.rail24_to_reset_release_ms};
			REG_RST_TO_R24: prdata = {{(DATA_W-DLY_W){1'b0}}, cfg_q.reset_to_rail24_off_ms};
			REG_R24_TO_R3:  prdata = {{(DATA_W-DLY_W){1'b0}}, cfg_q.rail24_to_rail3_off_ms};
			default:        prdata = '0;
		endcase
	end

endmodule

[sv/pbrs_seq_core.sv]
// ----------------------------------------------------------------------------
// pbrs_seq_core
// button hold counter and power phase sequencer, one step per item
// ----------------------------------------------------------------------------
`include "power_button_rail_sequencer_top_defines.svh"

module pbrs_seq_core
	import pbrs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  tick_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic [2:0]       phase_q, ph;
	logic [DLY_W-1:0] delay_q, dly;
	logic [DLY_W-1:0] hold_q, hold;
	logic             lps_q, lps;
	logic             pressed_q, pressed;
	logic             flag_q, flag;
	logic             start, stop;

	function automatic logic is_wait(input logic [2:0] p);
		return (p == PH_UP_WAIT24) || (p == PH_UP_WAIT_RST) ||
			(p == PH_DOWN_WAIT24) || (p == PH_DOWN_WAIT3);
	endfunction

	always_comb begin
		ph      = (phase_q > PH_DOWN_WAIT3) ? PH_OFF : phase_q;
		dly     = delay_q;
		hold    = hold_q;
		lps     = lps_q;
		pressed = pressed_q;
		flag    = flag_q & ~item.clear_flag;
		start   = 1'b0;
		stop    = 1'b0;

		if (is_wait(ph) && (dly != '0))
			dly = dly - 16'd1;

		if (!item.button_level) begin
			pressed = 1'b1;
			if (hold != HOLD_MAX)
				hold = hold + 16'd1;
			if (!lps_q && (hold >= cfg.long_press_ms)) begin
				lps = 1'b1;
				if (ph == PH_ON) begin
					ph   = PH_DOWN_WAIT24;
					dly  = cfg.reset_to_rail24_off_ms;
					stop = 1'b1;
				end
			end
		end else begin
			if (pressed_q && !lps_q) begin
				if (ph == PH_OFF) begin
					ph  = PH_UP_WAIT24;
					dly = cfg.rail3_to_rail24_on_ms;
				end else if (ph == PH_ON) begin
					flag = 1'b1;
				end
			end
			pressed = 1'b0;
			hold    = '0;
			lps     = 1'b0;
		end

		// zero delays chain through at most two phases in one tick
		for (int i = 0; i < 2; i++) begin
			if (is_wait(ph) && (dly == '0)) begin
				unique case (ph)
					PH_UP_WAIT24: begin
						ph  = PH_UP_WAIT_RST;
						dly = cfg.rail24_to_reset_release_ms;
					end
					PH_UP_WAIT_RST: begin
						ph    = PH_ON;
						start = 1'b1;
					end
					PH_DOWN_WAIT24: begin
						ph  = PH_DOWN_WAIT3;
						dly = cfg.rail24_to_rail3_off_ms;
					end
					default: ph = PH_OFF;
				endcase
			end
		end

		res.rail3_enable  = (ph != PH_OFF);
		res.rail24_enable = (ph == PH_UP_WAIT_RST) || (ph == PH_ON) || (ph == PH_DOWN_WAIT24);
		res.reset_release = (ph == PH_ON);
		res.system_on     = (ph != PH_OFF) && (ph != PH_UP_WAIT24);
		res.button_flag   = flag;
		res.start_pulse   = start;
		res.stop_pulse    = stop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_OFF;
			delay_q   <= '0;
			hold_q    <= '0;
			lps_q     <= 1'b0;
			pressed_q <= 1'b0;
			flag_q    <= 1'b0;
		end else if (step) begin
			phase_q   <= ph;
			delay_q   <= dly;
			hold_q    <= hold;
			lps_q     <= lps;
			pressed_q <= pressed;
			flag_q    <= flag;
		end
	end

	`PBRS_ASSERT_NEXT(a_start_on, step && res.start_pulse, phase_q == PH_ON,
		"start pulse without entering on")
	`PBRS_ASSERT_NEXT(a_stop_down, step && res.stop_pulse,
		(phase_q == PH_DOWN_WAIT24) || (phase_q == PH_DOWN_WAIT3) || (phase_q == PH_OFF),
		"stop pulse without power-off sequence")
	`PBRS_ASSERT_NEXT(a_hold_sat, step && !item.button_level && (hold_q == HOLD_MAX),
		hold_q == HOLD_MAX, "hold counter wrapped")
	`PBRS_ASSERT_NEXT(a_idle_hold, !step, $stable(phase_q) && $stable(delay_q),
		"sequencer state moved without an item")

endmodule

[sv/power_button_rail_sequencer_top.sv]
// ----------------------------------------------------------------------------
// power_button_rail_sequencer_top
// power button long-press off and rail on/off sequencer with apb registers
// ----------------------------------------------------------------------------
//
// channel   payload    handshake                     direction
// tick      tick_t     tick_valid / tick_stall       in
// result    result_t   result_valid / result_stall   out
// apb       32-bit     psel penable pwrite pready    config
//
// one item per clock while the result is not stalled; each item passes
// through the input register and leaves through the result register
// the phase, delay and hold state updates in that single pass
// reset clears control state and loads the register defaults, no clearing pass
// a stalled result holds and lets one more item wait in the input register
// ----------------------------------------------------------------------------
module power_button_rail_sequencer_top
	import pbrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// tick channel
	input  logic              tick_valid,
	output logic              tick_stall,
	input  tick_t             tick,
	// result channel
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// input register
	logic    valid_s1;
	tick_t   tick_s1;
	// result register
	logic    result_valid_q;
	result_t result_q;

	logic    out_free;
	logic    step;
	logic    tick_take;
	cfg_t    cfg;
	result_t res;

	// result register can load when empty or being drained this cycle
	assign out_free   = !result_valid_q || !result_stall;
	assign step       = valid_s1 && out_free;
	assign tick_stall = valid_s1 && !out_free;
	assign tick_take  = tick_valid && !tick_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	pbrs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer state advances only when an item moves into the result register
	pbrs_seq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (tick_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (tick_take)
				valid_s1 <= 1'b1;
			else if (step)
				valid_s1 <= 1'b0;
			if (step)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (tick_take)
			tick_s1 <= tick;
		if (step)
			result_q <= res;
	end

endmodule
